>>> src/dbd_pkg.sv
// ----------------------------------------------------------------------------
// dbd_pkg
// Shared types and constants of the delta block bitstream decoder.
// ----------------------------------------------------------------------------
package dbd_pkg;

  // Channel and buffer sizes.
  localparam int MAX_CHANNELS     = 4;
  localparam int BIT_BUFFER_WIDTH = 32;
  localparam int BIT_COUNT_W      = $clog2(BIT_BUFFER_WIDTH + 1);
  localparam int PACK_WIDTH       = 16;
  localparam int PACK_COUNT_W     = $clog2(PACK_WIDTH + 1);
  localparam int METHOD_W         = 7;
  localparam int FRAMES_W         = 9;

  // Configuration register indexes.
  localparam logic [2:0] REG_BLOCK_SIZE_BITS = 3'd0;
  localparam logic [2:0] REG_CHANNEL_COUNT   = 3'd1;
  localparam logic [2:0] REG_CHANNEL_WIDTHS  = 3'd2;
  localparam logic [2:0] REG_METHOD_WIDTHS   = 3'd3;
  localparam logic [2:0] REG_FRAME_BITS      = 3'd4;
  localparam logic [2:0] REG_WINDOW_MODE     = 3'd5;

  // Request commands.
  localparam logic CMD_PUSH   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NEED_BYTE   = 2'd1;
  localparam logic [1:0] ST_BUFFER_FULL = 2'd2;

  // Window modes.
  localparam logic [1:0] WM_FIXED          = 2'd0;
  localparam logic [1:0] WM_ADAPTIVE       = 2'd1;
  localparam logic [1:0] WM_FIXED_FIRST    = 2'd2;
  localparam logic [1:0] WM_ADAPTIVE_FIRST = 2'd3;

  // Syntax element expected by the next decode command.
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_METHOD = 4'b0010,
    PH_BASE   = 4'b0100,
    PH_VALUE  = 4'b1000
  } phase_t;

  // Mask of the low n bits of a byte; n of eight or more gives all ones.
  function automatic logic [7:0] low_mask8(input logic [METHOD_W-1:0] n);
    logic [8:0] one_hot;
    one_hot = 9'd1 << n[3:0];
    if (n >= METHOD_W'(8)) begin
      return 8'hFF;
    end
    return 8'(one_hot - 9'd1);
  endfunction

endpackage

>>> src/dbd_in_if.sv
// ----------------------------------------------------------------------------
// dbd_in_if
// Request channel: a command and a compressed byte.
// ----------------------------------------------------------------------------
interface dbd_in_if
  import dbd_pkg::*;
;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

>>> src/dbd_out_if.sv
// ----------------------------------------------------------------------------
// dbd_out_if
// Result channel: status, decoded channel value and emitted frame.
// ----------------------------------------------------------------------------
interface dbd_out_if
  import dbd_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       value_valid;
  logic [7:0] channel_value;
  logic [1:0] channel_index;
  logic       frame_valid;
  logic [7:0] frame_value;

  modport source (output valid, status, value_valid, channel_value, channel_index,
                  frame_valid, frame_value, input ready);
  modport sink   (input valid, status, value_valid, channel_value, channel_index,
                  frame_valid, frame_value, output ready);
endinterface

>>> src/delta_block_bitstream_decoder.sv
// ----------------------------------------------------------------------------
// delta_block_bitstream_decoder
// Decodes a delta-coded block bitstream one syntax element per request and
// packs the channel values into output frames.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake     payload
//   cmd       in   valid/ready   command, data_byte
//   res       out  valid/ready   status, value_valid, channel_value,
//                                channel_index, frame_valid, frame_value
//   cfg_*     in   write enable  cfg_index, cfg_data
//
// Every request is decoded in the cycle it is accepted and its result is
// registered, so one request per cycle is sustained while results are
// taken; the result appears in the cycle after acceptance. The decode is a
// combinational path through the bit buffer shifter, window adder and packer.
// rst is synchronous and clears all decoder state and restores the register
// defaults. A stalled result holds cmd.ready low until it is taken.
// ----------------------------------------------------------------------------
module delta_block_bitstream_decoder
  import dbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  dbd_in_if.sink      cmd,
  dbd_out_if.source   res
);

  // Configuration registers.
  logic [3:0]  block_size_bits;
  logic [2:0]  channel_count;
  logic [15:0] channel_widths;
  logic [11:0] method_widths;
  logic [3:0]  frame_bits;
  logic [1:0]  window_mode;

  // Decoder state.
  logic [BIT_BUFFER_WIDTH-1:0] bit_buffer, bit_buffer_next;
  logic [BIT_COUNT_W-1:0]      bit_count, bit_count_next;
  phase_t                      element_phase, element_phase_next;
  logic [1:0]                  channel_counter, channel_counter_next;
  logic [FRAMES_W-1:0]         frames_left, frames_left_next;
  logic                        first_frame, first_frame_next;
  logic [METHOD_W-1:0]         channel_method [MAX_CHANNELS];
  logic [7:0]                  channel_base   [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0]     adaptive_flag;
  logic [METHOD_W-1:0]         method_next;
  logic [7:0]                  base_next;
  logic                        adaptive_next;
  logic                        method_we, base_we, adaptive_we;
  logic [PACK_WIDTH-1:0]       pack_buffer, pack_buffer_next;
  logic [PACK_COUNT_W-1:0]     pack_count, pack_count_next;

  // Result register.
  logic       res_valid;
  logic [1:0] res_status, status_next;
  logic       res_value_valid, value_valid_next;
  logic [7:0] res_channel_value, channel_value_next;
  logic [1:0] res_channel_index, channel_index_next;
  logic       res_frame_valid, frame_valid_next;
  logic [7:0] res_frame_value, frame_value_next;

  // Decode datapath.
  logic                   accept;
  logic [3:0]             width_field;
  logic [3:0]             chan_w;
  logic [2:0]             meth_w;
  logic [2:0]             eff_channels;
  logic [2:0]             counter_inc;
  logic [METHOD_W-1:0]    need_bits;
  logic                   enough;
  logic [BIT_COUNT_W-1:0] peek_shift;
  logic [BIT_BUFFER_WIDTH-1:0] peek_word;
  logic [7:0]             peek;
  logic [METHOD_W-1:0]    cur_method;
  logic [7:0]             cur_base;
  logic                   cur_adaptive;
  logic                   reads;
  logic [7:0]             win, half, max_start, start, value;
  logic [3:0]             frame_w;
  logic [PACK_WIDTH-1:0]  pack_shifted;
  logic [PACK_COUNT_W:0]  pack_sum;
  logic [PACK_COUNT_W-1:0] pack_sat;
  logic [PACK_COUNT_W-1:0] pack_left;
  logic [PACK_WIDTH-1:0]  frame_word;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = !res_valid || res.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size_bits <= 4'd4;
      channel_count   <= 3'd1;
      channel_widths  <= 16'd8;
      method_widths   <= 12'd4;
      frame_bits      <= 4'd8;
      window_mode     <= WM_FIXED;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BLOCK_SIZE_BITS: block_size_bits <= cfg_data[3:0];
        REG_CHANNEL_COUNT:   channel_count   <= cfg_data[2:0];
        REG_CHANNEL_WIDTHS:  channel_widths  <= cfg_data;
        REG_METHOD_WIDTHS:   method_widths   <= cfg_data[11:0];
        REG_FRAME_BITS:      frame_bits      <= cfg_data[3:0];
        REG_WINDOW_MODE:     window_mode     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Per-channel field selection and register clamps.
  always_comb begin
    width_field = channel_widths[{channel_counter, 2'b00} +: 4];
    if (width_field == 4'd0) begin
      chan_w = 4'd1;
    end else if (width_field > 4'd8) begin
      chan_w = 4'd8;
    end else begin
      chan_w = width_field;
    end
    meth_w = method_widths[3 * channel_counter +: 3];
    if (channel_count == 3'd0) begin
      eff_channels = 3'd1;
    end else if (channel_count > 3'(MAX_CHANNELS < 4 ? MAX_CHANNELS : 4)) begin
      eff_channels = 3'(MAX_CHANNELS < 4 ? MAX_CHANNELS : 4);
    end else begin
      eff_channels = channel_count;
    end
    if (frame_bits == 4'd0) begin
      frame_w = 4'd1;
    end else if (frame_bits > 4'd8) begin
      frame_w = 4'd8;
    end else begin
      frame_w = frame_bits;
    end
    cur_method   = channel_method[channel_counter];
    cur_base     = channel_base[channel_counter];
    cur_adaptive = adaptive_flag[channel_counter];
    counter_inc  = {1'b0, channel_counter} + 3'd1;
  end

  // Bit buffer peek: the next need_bits bits, low byte only.
  always_comb begin
    unique case (element_phase)
      PH_HEADER: need_bits = (block_size_bits > 4'd8) ? METHOD_W'(8)
                                                      : METHOD_W'(block_size_bits);
      PH_METHOD: need_bits = METHOD_W'(meth_w);
      PH_BASE:   need_bits = METHOD_W'(chan_w);
      PH_VALUE:  need_bits = cur_method;
      default:   need_bits = '0;
    endcase
    enough     = METHOD_W'(bit_count) >= need_bits;
    peek_shift = bit_count - need_bits[BIT_COUNT_W-1:0];
    peek_word  = bit_buffer >> peek_shift;
    peek       = peek_word[7:0] & low_mask8(need_bits);
  end

  // Value rules: fixed offset or adaptive floating window.
  always_comb begin
    reads     = (cur_method != '0) && !(cur_adaptive && first_frame);
    win       = (cur_method < METHOD_W'(8)) ? (8'd1 << cur_method[2:0]) : 8'd0;
    half      = win >> 1;
    max_start = low_mask8(METHOD_W'(chan_w)) - win + 8'd1;
    if (half < cur_base) begin
      start = cur_base - half;
      if (start > max_start) begin
        start = max_start;
      end
    end else begin
      start = 8'd0;
    end
    if (!reads) begin
      value = cur_base;
    end else if (cur_adaptive) begin
      value = start + peek;
    end else begin
      value = cur_base + peek;
    end
  end

  // Frame packer.
  always_comb begin
    pack_shifted = (pack_buffer << chan_w) | PACK_WIDTH'(value);
    pack_sum     = {1'b0, pack_count} + (PACK_COUNT_W + 1)'(chan_w);
    pack_sat     = (pack_sum > (PACK_COUNT_W + 1)'(PACK_WIDTH))
                   ? PACK_COUNT_W'(PACK_WIDTH) : pack_sum[PACK_COUNT_W-1:0];
    pack_left    = pack_sat - PACK_COUNT_W'(frame_w);
    frame_word   = pack_shifted >> pack_left;
  end

  // Element decoder: next state and result.
  always_comb begin
    bit_buffer_next      = bit_buffer;
    bit_count_next       = bit_count;
    element_phase_next   = element_phase;
    channel_counter_next = channel_counter;
    frames_left_next     = frames_left;
    first_frame_next     = first_frame;
    pack_buffer_next     = pack_buffer;
    pack_count_next      = pack_count;
    method_next          = cur_method;
    base_next            = cur_base;
    adaptive_next        = cur_adaptive;
    method_we            = 1'b0;
    base_we              = 1'b0;
    adaptive_we          = 1'b0;
    status_next          = ST_OK;
    value_valid_next     = 1'b0;
    channel_value_next   = 8'd0;
    channel_index_next   = 2'd0;
    frame_valid_next     = 1'b0;
    frame_value_next     = 8'd0;

    if (cmd.command == CMD_PUSH) begin
      if (bit_count > BIT_COUNT_W'(BIT_BUFFER_WIDTH - 8)) begin
        status_next = ST_BUFFER_FULL;
      end else begin
        bit_buffer_next = {bit_buffer[BIT_BUFFER_WIDTH-9:0], cmd.data_byte};
        bit_count_next  = bit_count + BIT_COUNT_W'(8);
      end
    end else begin
      unique case (element_phase)
        PH_HEADER: begin
          if (!enough) begin
            status_next = ST_NEED_BYTE;
          end else begin
            frames_left_next     = FRAMES_W'(peek) + FRAMES_W'(1);
            bit_count_next       = peek_shift;
            first_frame_next     = 1'b1;
            channel_counter_next = 2'd0;
            element_phase_next   = PH_METHOD;
          end
        end
        PH_METHOD: begin
          if (!enough) begin
            status_next = ST_NEED_BYTE;
          end else begin
            bit_count_next = peek_shift;
            method_next    = METHOD_W'(peek);
            method_we      = 1'b1;
            if (METHOD_W'(peek) != METHOD_W'(chan_w)) begin
              element_phase_next = PH_BASE;
            end else begin
              base_next     = 8'd0;
              adaptive_next = 1'b0;
              base_we       = 1'b1;
              adaptive_we   = 1'b1;
              if (counter_inc >= eff_channels) begin
                channel_counter_next = 2'd0;
                element_phase_next   = PH_VALUE;
              end else begin
                channel_counter_next = counter_inc[1:0];
              end
            end
          end
        end
        PH_BASE: begin
          if (!enough) begin
            status_next = ST_NEED_BYTE;
          end else begin
            bit_count_next = peek_shift;
            base_next      = peek;
            base_we        = 1'b1;
            adaptive_we    = 1'b1;
            case (window_mode)
              WM_FIXED:    adaptive_next = 1'b0;
              WM_ADAPTIVE: adaptive_next = 1'b1;
              default: begin
                // Mixed modes: a method above the width selects the other rule.
                if (cur_method > METHOD_W'(chan_w)) begin
                  method_next = cur_method - METHOD_W'(chan_w);
                  method_we   = 1'b1;
                end
                adaptive_next = (window_mode == WM_FIXED_FIRST)
                                ? (cur_method > METHOD_W'(chan_w))
                                : (cur_method <= METHOD_W'(chan_w));
              end
            endcase
            if (counter_inc >= eff_channels) begin
              channel_counter_next = 2'd0;
              element_phase_next   = PH_VALUE;
            end else begin
              channel_counter_next = counter_inc[1:0];
              element_phase_next   = PH_METHOD;
            end
          end
        end
        PH_VALUE: begin
          if (reads && !enough) begin
            status_next = ST_NEED_BYTE;
          end else begin
            if (reads) begin
              bit_count_next = peek_shift;
              if (cur_adaptive) begin
                base_next = value;
                base_we   = 1'b1;
              end
            end
            value_valid_next   = 1'b1;
            channel_value_next = value;
            channel_index_next = channel_counter;
            pack_buffer_next   = pack_shifted;
            pack_count_next    = pack_sat;
            if (pack_sat >= PACK_COUNT_W'(frame_w)) begin
              pack_count_next  = pack_left;
              frame_valid_next = 1'b1;
              frame_value_next = frame_word[7:0] & low_mask8(METHOD_W'(frame_w));
            end
            if (counter_inc >= eff_channels) begin
              channel_counter_next = 2'd0;
              first_frame_next     = 1'b0;
              if (frames_left != '0) begin
                frames_left_next = frames_left - FRAMES_W'(1);
              end
              if (frames_left <= FRAMES_W'(1)) begin
                element_phase_next = PH_HEADER;
              end
            end else begin
              channel_counter_next = counter_inc[1:0];
            end
          end
        end
        default: element_phase_next = PH_HEADER;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer      <= '0;
      bit_count       <= '0;
      element_phase   <= PH_HEADER;
      channel_counter <= 2'd0;
      frames_left     <= '0;
      first_frame     <= 1'b0;
      adaptive_flag   <= '0;
      pack_buffer     <= '0;
      pack_count      <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        channel_method[i] <= '0;
        channel_base[i]   <= '0;
      end
    end else if (accept) begin
      bit_buffer      <= bit_buffer_next;
      bit_count       <= bit_count_next;
      element_phase   <= element_phase_next;
      channel_counter <= channel_counter_next;
      frames_left     <= frames_left_next;
      first_frame     <= first_frame_next;
      pack_buffer     <= pack_buffer_next;
      pack_count      <= pack_count_next;
      if (method_we) begin
        channel_method[channel_counter] <= method_next;
      end
      if (base_we) begin
        channel_base[channel_counter] <= base_next;
      end
      if (adaptive_we) begin
        adaptive_flag[channel_counter] <= adaptive_next;
      end
    end
  end

  // Result register: loads on accept, clears when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status        <= status_next;
      res_value_valid   <= value_valid_next;
      res_channel_value <= channel_value_next;
      res_channel_index <= channel_index_next;
      res_frame_valid   <= frame_valid_next;
      res_frame_value   <= frame_value_next;
    end
  end

  assign res.valid         = res_valid;
  assign res.status        = res_status;
  assign res.value_valid   = res_value_valid;
  assign res.channel_value = res_channel_value;
  assign res.channel_index = res_channel_index;
  assign res.frame_valid   = res_frame_valid;
  assign res.frame_value   = res_frame_value;

  // The bit buffer never holds more bits than it has room for.
  assert property (@(posedge clk) disable iff (rst)
    bit_count <= BIT_COUNT_W'(BIT_BUFFER_WIDTH))
    else $error("bit_count exceeds the bit buffer width");

  // The packer never counts more bits than its buffer holds.
  assert property (@(posedge clk) disable iff (rst)
    pack_count <= PACK_COUNT_W'(PACK_WIDTH))
    else $error("pack_count exceeds the pack buffer width");

  // A frame is only emitted together with a decoded value.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_frame_valid |-> res_value_valid && (res_status == ST_OK))
    else $error("frame emitted without a decoded value");

  // A push with room adds exactly one byte to the bit buffer.
  assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.command == CMD_PUSH)
      && (bit_count <= BIT_COUNT_W'(BIT_BUFFER_WIDTH - 8))
    |=> bit_count == $past(bit_count) + BIT_COUNT_W'(8))
    else $error("push did not add one byte to the bit buffer");

endmodule

>>> test/dbd_decode_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dbd_decode_checker
// Watches the request, result and register channels of the decoder, predicts
// each result from its own model of the bit buffer, element sequencer and
// frame packer, and compares every returned result field by field.
// ----------------------------------------------------------------------------
module dbd_decode_checker
  import dbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  dbd_in_if           cmd,
  dbd_out_if          res,
  output int          mismatches,
  output int          pending,
  output int          requests_seen,
  output int          values_seen,
  output int          frames_seen,
  output int          starved_seen,
  output int          dropped_seen
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [1:0] status;
    logic       value_valid;
    logic [7:0] channel_value;
    logic [1:0] channel_index;
    logic       frame_valid;
    logic [7:0] frame_value;
  } dec_result_t;

  // Results predicted for accepted requests, oldest first.
  dec_result_t expected_results[$];

  // Decoder state as predicted.
  logic [BIT_BUFFER_WIDTH-1:0] stream_bits;
  int unsigned                 stream_fill;
  phase_t                      next_element;
  int unsigned                 chan_slot;
  int unsigned                 frames_to_go;
  bit                          opening_frame;
  int unsigned                 chan_rule [MAX_CHANNELS];
  int unsigned                 chan_last [MAX_CHANNELS];
  bit                          chan_floating [MAX_CHANNELS];
  int unsigned                 packer_bits;
  int unsigned                 packer_fill;

  // Register copies as last written.
  int unsigned cfg_header_bits;
  int unsigned cfg_channels;
  int unsigned cfg_value_widths;
  int unsigned cfg_rule_widths;
  int unsigned cfg_frame_bits;
  logic [1:0]  cfg_window;

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic int unsigned ones(int unsigned n);
    if (n >= 32) begin
      return 32'hFFFF_FFFF;
    end
    return (32'd1 << n) - 32'd1;
  endfunction

  function automatic int unsigned live_channels();
    return clamp(cfg_channels, 1, (MAX_CHANNELS < 4) ? MAX_CHANNELS : 4);
  endfunction

  function automatic int unsigned value_width(int unsigned c);
    return clamp((cfg_value_widths >> (4 * (c & 3))) & 15, 1, 8);
  endfunction

  function automatic int unsigned rule_width(int unsigned c);
    return (cfg_rule_widths >> (3 * (c & 3))) & 7;
  endfunction

  // Look at the next n bits, MSB first, without consuming them.
  function automatic int unsigned peek_stream(int unsigned n);
    if (n == 0) begin
      return 0;
    end
    return int'(stream_bits >> (stream_fill - n)) & ones(n);
  endfunction

  function automatic string describe(dec_result_t r);
    return $sformatf("status=%0d value_valid=%0b channel_value=%02h channel_index=%0d frame_valid=%0b frame_value=%02h",
                     r.status, r.value_valid, r.channel_value, r.channel_index,
                     r.frame_valid, r.frame_value);
  endfunction

  task automatic reset_model();
    stream_bits   = '0;
    stream_fill   = 0;
    next_element  = PH_HEADER;
    chan_slot     = 0;
    frames_to_go  = 0;
    opening_frame = 1'b0;
    packer_bits   = 0;
    packer_fill   = 0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      chan_rule[i]     = 0;
      chan_last[i]     = 0;
      chan_floating[i] = 1'b0;
    end
    cfg_header_bits  = 4;
    cfg_channels     = 1;
    cfg_value_widths = 8;
    cfg_rule_widths  = 4;
    cfg_frame_bits   = 8;
    cfg_window       = WM_FIXED;
  endtask

  task automatic write_model_reg(input logic [2:0] idx, input logic [15:0] d);
    case (idx)
      REG_BLOCK_SIZE_BITS: cfg_header_bits = d & 16'h000F;
      REG_CHANNEL_COUNT:   cfg_channels = d & 16'h0007;
      REG_CHANNEL_WIDTHS:  cfg_value_widths = d;
      REG_METHOD_WIDTHS:   cfg_rule_widths = d & 16'h0FFF;
      REG_FRAME_BITS:      cfg_frame_bits = d & 16'h000F;
      REG_WINDOW_MODE:     cfg_window = d[1:0];
      default: ;
    endcase
  endtask

  // After a method or base, step to the next channel or on to the values.
  task automatic close_channel_setup();
    chan_slot++;
    if (chan_slot >= live_channels()) begin
      chan_slot    = 0;
      next_element = PH_VALUE;
    end else begin
      next_element = PH_METHOD;
    end
  endtask

  // Apply one request to the model and work out the result it causes.
  task automatic decode_request(input logic command, input logic [7:0] byte_in,
                                output dec_result_t r);
    int unsigned c, n, m, cw, v, bits, win, half, top_start, fb;
    bit reads, above;
    r = '0;
    c = chan_slot & 3;
    if (command == CMD_PUSH) begin
      // A byte that would overflow the buffer is dropped.
      if (stream_fill + 8 > BIT_BUFFER_WIDTH) begin
        r.status = ST_BUFFER_FULL;
      end else begin
        stream_bits = (stream_bits << 8) | BIT_BUFFER_WIDTH'(byte_in);
        stream_fill += 8;
      end
    end else begin
      case (next_element)
        PH_HEADER: begin
          n = clamp(cfg_header_bits, 0, 8);
          if (stream_fill < n) begin
            r.status = ST_NEED_BYTE;
          end else begin
            frames_to_go  = peek_stream(n) + 1;
            stream_fill  -= n;
            opening_frame = 1'b1;
            chan_slot     = 0;
            next_element  = PH_METHOD;
          end
        end
        PH_METHOD: begin
          n = rule_width(c);
          if (stream_fill < n) begin
            r.status = ST_NEED_BYTE;
          end else begin
            m = peek_stream(n);
            stream_fill -= n;
            chan_rule[c] = m;
            if (m != value_width(c)) begin
              next_element = PH_BASE;
            end else begin
              // Raw values: no base follows.
              chan_last[c]     = 0;
              chan_floating[c] = 1'b0;
              close_channel_setup();
            end
          end
        end
        PH_BASE: begin
          cw = value_width(c);
          if (stream_fill < cw) begin
            r.status = ST_NEED_BYTE;
          end else begin
            m = chan_rule[c];
            chan_last[c] = peek_stream(cw);
            stream_fill -= cw;
            if (cfg_window == WM_FIXED) begin
              chan_floating[c] = 1'b0;
            end else if (cfg_window == WM_ADAPTIVE) begin
              chan_floating[c] = 1'b1;
            end else begin
              // Mixed modes: a method above the width picks the second kind.
              above = m > cw;
              if (above) begin
                chan_rule[c] = m - cw;
              end
              chan_floating[c] = (cfg_window == WM_FIXED_FIRST) ? above : !above;
            end
            close_channel_setup();
          end
        end
        PH_VALUE: begin
          cw    = value_width(c);
          m     = chan_rule[c];
          v     = chan_last[c];
          reads = (m != 0) && !(chan_floating[c] && opening_frame);
          if (reads && stream_fill < m) begin
            r.status = ST_NEED_BYTE;
          end else begin
            if (reads) begin
              bits = peek_stream(m);
              stream_fill -= m;
              if (chan_floating[c]) begin
                // Floating window around the previous value, byte arithmetic.
                win       = (m < 8) ? ((32'd1 << m) & 8'hFF) : 0;
                half      = win >> 1;
                top_start = (ones(cw) - win + 1) & 8'hFF;
                if (half < v) begin
                  v = (v - half) & 8'hFF;
                  if (v > top_start) begin
                    v = top_start;
                  end
                end else begin
                  v = 0;
                end
                v = (v + bits) & 8'hFF;
                chan_last[c] = v;
              end else begin
                v = (v + bits) & 8'hFF;
              end
            end
            r.value_valid   = 1'b1;
            r.channel_value = v[7:0];
            r.channel_index = c[1:0];
            // Pack MSB first; at most one frame leaves per value.
            packer_bits = ((packer_bits << cw) | v) & 16'hFFFF;
            packer_fill = clamp(packer_fill + cw, 0, 16);
            fb = clamp(cfg_frame_bits, 1, 8);
            if (packer_fill >= fb) begin
              packer_fill  -= fb;
              r.frame_valid = 1'b1;
              r.frame_value = 8'((packer_bits >> packer_fill) & ones(fb));
            end
            chan_slot++;
            if (chan_slot >= live_channels()) begin
              chan_slot     = 0;
              opening_frame = 1'b0;
              if (frames_to_go > 0) begin
                frames_to_go--;
              end
              if (frames_to_go == 0) begin
                next_element = PH_HEADER;
              end
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  // Compare returned results first, then predict for a new request.
  always @(posedge clk) begin : monitor
    dec_result_t got;
    dec_result_t want;
    if (rst) begin
      reset_model();
      expected_results.delete();
      mismatches    = 0;
      requests_seen = 0;
      values_seen   = 0;
      frames_seen   = 0;
      starved_seen  = 0;
      dropped_seen  = 0;
    end else begin
      if (cfg_write) begin
        write_model_reg(cfg_index, cfg_data);
      end
      if (res.valid && res.ready) begin
        got.status        = res.status;
        got.value_valid   = res.value_valid;
        got.channel_value = res.channel_value;
        got.channel_index = res.channel_index;
        got.frame_valid   = res.frame_valid;
        got.frame_value   = res.frame_value;
        if (expected_results.size() == 0) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("%0t: result with no request waiting: %s", $realtime, describe(got));
          end
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                       $realtime, describe(want), describe(got));
            end
            mismatches++;
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        decode_request(cmd.command, cmd.data_byte, want);
        expected_results.push_back(want);
        requests_seen++;
        values_seen  += want.value_valid;
        frames_seen  += want.frame_valid;
        starved_seen += (want.status == ST_NEED_BYTE);
        dropped_seen += (want.status == ST_BUFFER_FULL);
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the delta block bitstream decoder: directed requests from
// reset, then random push and decode traffic under a series of register
// settings, with random stalls on both channels; a checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import dbd_pkg::*;

  localparam int HALF_PERIOD       = 10;
  localparam int RESET_CYCLES      = 8;
  localparam int STALL_LIMIT       = 2000;
  localparam int LONG_HOLD         = 64;
  localparam int SETTING_COUNT     = 12;
  localparam int ITEMS_PER_SETTING = 45;
  localparam int HOLD_SETTING      = 5;
  localparam int PAUSE_SETTING     = 8;
  localparam int SETTLE_CYCLES     = 4;

  // Indexes past the last register; writes to them must be ignored.
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = REG_BLOCK_SIZE_BITS;
  logic [15:0] cfg_data  = '0;

  int mismatches, pending;
  int requests_seen, values_seen, frames_seen, starved_seen, dropped_seen;
  int idle_cycles = 0;
  int hold_asks   = 0;
  int hold_served = 0;
  int send_steady = 0;

  dbd_in_if  cmd_ch ();
  dbd_out_if res_ch ();

  always #(HALF_PERIOD) clk = ~clk;

  delta_block_bitstream_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  dbd_decode_checker u_decode_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd_ch),
    .res           (res_ch),
    .mismatches    (mismatches),
    .pending       (pending),
    .requests_seen (requests_seen),
    .values_seen   (values_seen),
    .frames_seen   (frames_seen),
    .starved_seen  (starved_seen),
    .dropped_seen  (dropped_seen)
  );

  // Offer one request after a random gap and wait until it is accepted.
  task automatic send_request(input logic command, input logic [7:0] byte_in);
    int gap;
    int r;
    gap = 0;
    if (send_steady > 0) begin
      send_steady--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_steady = $urandom_range(20, 60);
      end else if (r < 25) begin
        gap = $urandom_range(1, 3);
      end else if (r < 29) begin
        gap = $urandom_range(8, 25);
      end
    end
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.command   <= command;
    cmd_ch.data_byte <= byte_in;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Stop offering and wait until every predicted result has been returned.
  task automatic drain_results();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [15:0] d);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
  endtask

  // Program all registers; the first settings are fixed corner cases, the
  // last one the widest, the rest random with junk in the unused upper bits.
  task automatic program_setting(input int k);
    logic [15:0] d [6];
    logic [15:0] w;
    int f;
    case (k)
      0: d = '{16'h0000, 16'h0001, 16'h1111, 16'h0000, 16'h0001, 16'(WM_FIXED)};
      1: d = '{16'h0000, 16'h0004, 16'h8181, 16'h0924, 16'h0001, 16'(WM_ADAPTIVE)};
      2: d = '{16'hFFFF, 16'hFFF8, 16'h0F90, 16'hF8D1, 16'hFFF0, 16'(WM_FIXED_FIRST)};
      3: d = '{16'h0001, 16'h0007, 16'h2143, 16'h0323, 16'h000F, 16'(WM_ADAPTIVE_FIRST)};
      SETTING_COUNT - 1:
         d = '{16'hFFF8, 16'hFFFC, 16'h8888, 16'hFFFF, 16'h0008, 16'(WM_ADAPTIVE)};
      default: begin
        // Short blocks most of the time so headers come round often.
        f = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
        d[0] = {12'($urandom), 4'(f)};
        d[1] = {13'($urandom), 3'($urandom_range(0, 7))};
        if ($urandom_range(0, 1) == 0) begin
          w = 16'($urandom);
        end else begin
          for (int i = 0; i < 4; i++) begin
            w[4*i +: 4] = 4'($urandom_range(1, 8));
          end
        end
        d[2] = w;
        // Methods up to four bits stay decodable within the buffer.
        d[3] = {4'($urandom), 3'($urandom_range(0, 4)), 3'($urandom_range(0, 4)),
                3'($urandom_range(0, 4)), 3'($urandom_range(0, 4))};
        d[4] = {12'($urandom), 4'($urandom_range(0, 15))};
        d[5] = {14'($urandom), 2'($urandom_range(0, 3))};
      end
    endcase
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_register(REG_BLOCK_SIZE_BITS, d[0]);
    write_register(REG_CHANNEL_COUNT, d[1]);
    write_register(REG_CHANNEL_WIDTHS, d[2]);
    write_register(REG_METHOD_WIDTHS, d[3]);
    write_register(REG_FRAME_BITS, d[4]);
    write_register(REG_WINDOW_MODE, d[5]);
    if (k == 4) begin
      write_register(REG_SPARE_LO, 16'($urandom));
      write_register(REG_SPARE_HI, 16'($urandom));
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Result side: random stalls, quiet stretches, and a long hold on request.
  initial begin : result_taker
    int stall;
    int steady;
    int r;
    stall  = 0;
    steady = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_served) begin
        hold_served++;
        stall  = LONG_HOLD;
        steady = 0;
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        stall--;
      end else if (steady > 0) begin
        res_ch.ready <= 1'b1;
        steady--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          steady = $urandom_range(20, 60);
          res_ch.ready <= 1'b1;
        end else if (r < 25) begin
          res_ch.ready <= 1'b0;
          stall = (r < 22) ? $urandom_range(0, 2) : $urandom_range(10, 30);
        end else begin
          res_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("[delta_block_bitstream_decoder] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Request side and verdict.
  initial begin : stimulus
    int push_pct;
    cmd_ch.valid     = 1'b0;
    cmd_ch.command   = CMD_PUSH;
    cmd_ch.data_byte = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // From reset: decode on an empty buffer, fill to overflow, then decode.
    send_request(CMD_DECODE, 8'h00);
    send_request(CMD_PUSH, 8'hFF);
    send_request(CMD_PUSH, 8'h00);
    send_request(CMD_PUSH, 8'hA5);
    send_request(CMD_PUSH, 8'h5A);
    send_request(CMD_PUSH, 8'hC3);
    repeat (6) send_request(CMD_DECODE, 8'hFF);
    send_request(CMD_PUSH, 8'h81);
    repeat (5) send_request(CMD_DECODE, 8'h00);

    for (int k = 0; k < SETTING_COUNT; k++) begin
      drain_results();
      program_setting(k);
      push_pct = $urandom_range(25, 55);
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        if (k == HOLD_SETTING && i == 1) begin
          hold_asks++;
        end
        if (k == PAUSE_SETTING && i == ITEMS_PER_SETTING / 2) begin
          drain_results();
        end
        send_request(($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_DECODE,
                     8'($urandom));
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Run covered %0d requests under %0d register settings: %0d channel values, %0d frames.",
             requests_seen, SETTING_COUNT, values_seen, frames_seen);
    $display("Decodes short of bits: %0d, pushes into a full buffer: %0d, mismatches: %0d.",
             starved_seen, dropped_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("[delta_block_bitstream_decoder] OK");
    end else begin
      $display("[delta_block_bitstream_decoder] ERROR");
    end
    $finish;
  end

endmodule
